[src/slev_pkg.sv]
// Shared types, constants and helpers for the sprite list evaluator.
// No dependencies; every other file imports this package.
package slev_pkg;

	// Sizing
	localparam int SPRITE_COUNT = 64;
	localparam int LIST_BYTES   = 32;
	localparam int SN_W         = $clog2(SPRITE_COUNT + 1);
	localparam int FILL_W       = $clog2(LIST_BYTES + 1);
	localparam int LIST_AW      = (LIST_BYTES > 1) ? $clog2(LIST_BYTES) : 1;
	localparam int TABLE_DEPTH  = 256;

	// Line and dot boundaries
	localparam logic [8:0] VISIBLE_LINES = 9'd240;
	localparam logic [8:0] DOT_FIRST     = 9'd1;
	localparam logic [8:0] DOT_CLEAR_END = 9'd64;
	localparam logic [8:0] DOT_EVAL_GO   = 9'd65;
	localparam logic [8:0] DOT_EVAL_END  = 9'd256;
	localparam logic [8:0] DOT_FETCH_GO  = 9'd257;
	localparam logic [8:0] DOT_FETCH_END = 9'd320;
	localparam logic [8:0] DOT_LAST      = 9'd340;

	localparam logic [7:0] BUS_IDLE = 8'hFF;

	// Input item kinds
	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2
	} kind_e;

	// Configuration register indexes
	typedef enum logic {
		REG_RENDER = 1'b0,
		REG_TALL   = 1'b1
	} reg_e;

	typedef struct packed {
		logic       render_en;
		logic       tall_sprites;
	} cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [8:0] scanline;
		logic [8:0] dot;
		logic [7:0] table_address;
		logic [7:0] write_value;
	} item_t;

	// Primary table access for one transaction
	typedef struct packed {
		logic       rd_en;
		logic [7:0] rd_addr;
		logic       wr_en;
		logic [7:0] wr_addr;
		logic [7:0] wr_data;
	} mem_req_t;

	// Result; from_mem selects the registered table read as data
	typedef struct packed {
		logic [7:0] data;
		logic       from_mem;
		logic       hit;
		logic       clr;
	} result_t;

	// Row of the sprite on this line, wrapped to 8 bits, against its height
	function automatic logic in_range(input logic [8:0] line, input logic [7:0] y,
			input logic tall);
		logic [7:0] row;
		row = line[7:0] - y;
		return tall ? (row < 8'd16) : (row < 8'd8);
	endfunction

endpackage

[src/slev_table.sv]
// Primary sprite table: 256 bytes, one write and one registered read per cycle.
// Per-entry valid bits give the all-zero reset contents. Depends on slev_pkg.
module slev_table import slev_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output logic [7:0] rd_data
);

	logic [7:0]             mem_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [7:0]             rd_q;

	// Storage, no reset
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
	end

	// Valid bits; unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	// Registered read port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 8'h00;
		end else if (req.rd_en) begin
			rd_q <= valid_q[req.rd_addr] ? mem_q[req.rd_addr] : 8'h00;
		end
	end

	assign rd_data = rd_q;

endmodule

[src/slev_eval.sv]
// Per-dot evaluation: sequencing state, secondary list and bus value.
// Works on the item in the input register. Depends on slev_pkg.
module slev_eval import slev_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  item_t      item,
	input  cfg_t       cfg,
	input  logic [7:0] rd_data,
	output mem_req_t   req,
	output result_t    res
);

	logic [SN_W-1:0]   sn_q, sn_n;
	logic [1:0]        bn_q, bn_n;
	logic [FILL_W-1:0] fill_q, fill_n;
	logic              fin_q, fin_n;
	logic [7:0]        bus_q;
	logic              bus_mem_q;
	logic [7:0]        sec_q [LIST_BYTES];

	logic [7:0]         bus_cur, bus_next;
	logic               bus_load_mem;
	logic               active;
	logic               sec_clear, sec_we;
	logic [LIST_AW-1:0] sec_widx;
	logic [5:0]         phase;
	logic [4:0]         fetch_idx;

	// Bus value may still sit in the table read register
	assign bus_cur = bus_mem_q ? rd_data : bus_q;

	assign active = cfg.render_en && (item.scanline < VISIBLE_LINES)
		&& (item.dot >= DOT_FIRST) && (item.dot <= DOT_LAST);

	assign phase     = 6'(item.dot - DOT_FETCH_GO);
	assign fetch_idx = {phase[5:3], phase[2:1]};

	// Next state and result for the current transaction
	always_comb begin
		sn_n         = sn_q;
		bn_n         = bn_q;
		fill_n       = fill_q;
		fin_n        = fin_q;
		bus_next     = bus_cur;
		bus_load_mem = 1'b0;
		sec_clear    = 1'b0;
		sec_we       = 1'b0;
		sec_widx     = '0;
		req          = '0;
		res          = '0;

		unique case (item.kind)
			KIND_TICK: begin
				if (active) begin
					if (item.dot == DOT_FIRST || item.dot == DOT_EVAL_GO) begin
						sn_n   = '0;
						bn_n   = '0;
						fill_n = '0;
						fin_n  = 1'b0;
					end
					if (item.dot <= DOT_CLEAR_END) begin
						sec_clear = 1'b1;
						bus_next  = BUS_IDLE;
					end else if (item.dot <= DOT_EVAL_END) begin
						if (fin_n || (sn_n >= SN_W'(SPRITE_COUNT))) begin
							bus_next = BUS_IDLE;
							fin_n    = 1'b1;
						end else begin
							if (item.dot[0]) begin
								// odd dot: fetch sprite byte
								req.rd_en    = 1'b1;
								req.rd_addr  = 8'({sn_n, bn_n});
								bus_load_mem = 1'b1;
							end else if (fill_n < FILL_W'(LIST_BYTES)) begin
								// even dot: copy while the list has room
								if (bn_n == 2'd0) begin
									if (in_range(item.scanline, bus_cur, cfg.tall_sprites)) begin
										sec_we   = 1'b1;
										sec_widx = fill_n[LIST_AW-1:0];
										fill_n   = fill_n + FILL_W'(1);
										bn_n     = 2'd1;
									end else begin
										sn_n = sn_n + SN_W'(1);
									end
								end else begin
									sec_we   = 1'b1;
									sec_widx = fill_n[LIST_AW-1:0];
									fill_n   = fill_n + FILL_W'(1);
									if (bn_n == 2'd3) begin
										bn_n = 2'd0;
										sn_n = sn_n + SN_W'(1);
									end else begin
										bn_n = bn_n + 2'd1;
									end
								end
							end else begin
								// list full: diagonal overflow search
								if (in_range(item.scanline, bus_cur, cfg.tall_sprites)) begin
									res.hit = 1'b1;
									bn_n    = bn_n + 2'd1;
								end
								sn_n = sn_n + SN_W'(1);
							end
							if (sn_n >= SN_W'(SPRITE_COUNT)) begin
								fin_n = 1'b1;
							end
						end
					end else if (item.dot <= DOT_FETCH_END) begin
						bus_next = ({1'b0, fetch_idx} < 6'(LIST_BYTES))
							? sec_q[fetch_idx[LIST_AW-1:0]] : BUS_IDLE;
						res.clr  = 1'b1;
					end else begin
						req.rd_en    = 1'b1;
						req.rd_addr  = 8'h00;
						bus_load_mem = 1'b1;
						res.clr      = 1'b1;
					end
				end
				res.from_mem = bus_load_mem;
				res.data     = bus_load_mem ? 8'h00 : bus_next;
			end
			KIND_WRITE: begin
				req.wr_en   = 1'b1;
				req.wr_addr = item.table_address;
				req.wr_data = item.write_value;
			end
			KIND_READ: begin
				if (active) begin
					res.data = bus_cur;
				end else begin
					req.rd_en    = 1'b1;
					req.rd_addr  = item.table_address;
					res.from_mem = 1'b1;
				end
			end
			default: begin
				res = '0;
			end
		endcase

		if (!step) begin
			req.rd_en = 1'b0;
			req.wr_en = 1'b0;
		end
	end

	// Sequencing state and bus value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sn_q      <= '0;
			bn_q      <= '0;
			fill_q    <= '0;
			fin_q     <= 1'b0;
			bus_q     <= BUS_IDLE;
			bus_mem_q <= 1'b0;
		end else if (step) begin
			sn_q   <= sn_n;
			bn_q   <= bn_n;
			fill_q <= fill_n;
			fin_q  <= fin_n;
			if (bus_load_mem) begin
				bus_mem_q <= 1'b1;
			end else begin
				bus_q     <= bus_next;
				bus_mem_q <= 1'b0;
			end
		end
	end

	// Secondary list: bulk clear or one byte copied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LIST_BYTES; i++) begin
				sec_q[i] <= BUS_IDLE;
			end
		end else if (step) begin
			if (sec_clear) begin
				for (int i = 0; i < LIST_BYTES; i++) begin
					sec_q[i] <= BUS_IDLE;
				end
			end else if (sec_we) begin
				sec_q[sec_widx] <= bus_cur;
			end
		end
	end

endmodule

[src/sprite_list_evaluator.sv]
// Top level of the sprite list evaluator: input register, evaluation, table, result register.
// Depends on slev_pkg, slev_table and slev_eval.
//
// Usage:
//   Items arrive on item_valid/item_ready: a dot tick, a primary table write or a
//   sprite data read, selected by kind. Each transaction yields exactly one result
//   on result_valid/result_ready carrying data, overflow_hit and clear_address.
//   The two configuration registers (rendering enable, tall sprites) are written through
//   cfg_we/cfg_index/cfg_data; the user must write only while idle, the block does not check.
// Timing:
//   An accepted item passes through the input register, where evaluation runs and the
//   table read is issued, and then the result register, whose data may come straight
//   from the table read register.
//   Throughput is one item per cycle while result_ready stays high.
// Reset:
//   arst_n clears both pipeline stages, the evaluation state, the table (through
//   per-entry valid bits), fills the secondary list with 0xFF and drives the bus to 0xFF.
// Stalls:
//   While result_ready is low the result holds; the input register keeps one item,
//   so item_ready stays high until that register is occupied.
module sprite_list_evaluator import slev_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [1:0] kind,
	input  logic [8:0] scanline,
	input  logic [8:0] dot,
	input  logic [7:0] table_address,
	input  logic [7:0] write_value,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] data,
	output logic       overflow_hit,
	output logic       clear_address,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic       cfg_data
);

	logic     valid_s1, valid_s2;
	item_t    item_s1;
	result_t  res_s2;
	result_t  res;
	mem_req_t req;
	cfg_t     cfg_q;
	logic     advance;
	logic [7:0] rd_data;

	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_e'(cfg_index))
				REG_RENDER: cfg_q.render_en    <= cfg_data;
				REG_TALL:   cfg_q.tall_sprites <= cfg_data;
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= '{kind: kind, scanline: scanline, dot: dot,
				table_address: table_address, write_value: write_value};
		end
	end

	slev_eval u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.rd_data (rd_data),
		.req     (req),
		.res     (res)
	);

	slev_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign result_valid  = valid_s2;
	assign data          = res_s2.from_mem ? rd_data : res_s2.data;
	assign overflow_hit  = res_s2.hit;
	assign clear_address = res_s2.clr;

	// Overflow search and address clear happen on different dot ranges
	a_hit_clr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(overflow_hit && clear_address))
		else $error("overflow and address clear on the same result");

	// Table is touched only when a transaction moves on
	a_mem_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		(req.rd_en || req.wr_en) |-> advance)
		else $error("table access without a transaction advancing");

	// No overflow while rendering is off
	a_no_hit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !cfg_q.render_en) |=> !res_s2.hit)
		else $error("overflow raised with rendering disabled");

	// A stalled result keeps its table read data
	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !result_ready) |=> $stable(rd_data))
		else $error("table read data changed under a stalled result");

endmodule

[tb/slev_tb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the sprite list evaluator testbench: per-dot prediction and result checks.
// Depends on slev_pkg for the item type, the kind codes, register indexes and sizes.
package slev_tb_pkg;
	import slev_pkg::*;

	// Kind code that the block does not decode
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic       hit;
		logic       clr;
	} bus_result_t;

	class sprite_eval_scoreboard;
		// Predicted block state
		bit [7:0] table_bytes[TABLE_DEPTH];
		bit [7:0] list_bytes[LIST_BYTES];
		bit [7:0] bus;
		int unsigned sprite_idx;
		int unsigned byte_idx;
		int unsigned list_fill;
		bit eval_done;
		bit render_on;
		bit tall;

		// Results owed by the block, oldest first
		bus_result_t due_results[$];
		int errors;
		int checked;

		function new();
			foreach (table_bytes[i]) table_bytes[i] = 8'h00;
			foreach (list_bytes[i]) list_bytes[i] = BUS_IDLE;
			bus = BUS_IDLE;
			restart_eval();
			render_on = 1'b0;
			tall = 1'b0;
			errors = 0;
			checked = 0;
		endfunction

		function void set_config(reg_e idx, bit val);
			case (idx)
				REG_RENDER: render_on = val;
				REG_TALL:   tall = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void restart_eval();
			sprite_idx = 0;
			byte_idx = 0;
			list_fill = 0;
			eval_done = 1'b0;
		endfunction

		// Rendering owns the bus on visible lines, dots 1..340
		function bit rendering_dot(int unsigned line, int unsigned dot_no);
			return render_on && line < VISIBLE_LINES && dot_no >= DOT_FIRST
				&& dot_no <= DOT_LAST;
		endfunction

		// Row offset wraps at 256
		function bit sprite_on_line(int unsigned line, bit [7:0] y);
			bit [7:0] row;
			row = 8'(line) - y;
			return tall ? (row < 8'd16) : (row < 8'd8);
		endfunction

		// One evaluation dot; returns the overflow pulse
		function bit evaluate_dot(int unsigned line, int unsigned dot_no);
			bit hit;
			bit [7:0] idx;
			hit = 1'b0;
			if ((dot_no % 2) == 1) begin
				idx = 8'((sprite_idx << 2) | byte_idx);
				bus = table_bytes[idx];
				return 1'b0;
			end
			if (list_fill < LIST_BYTES) begin
				if (byte_idx == 0) begin
					if (sprite_on_line(line, bus)) begin
						list_bytes[list_fill] = bus;
						list_fill++;
						byte_idx = 1;
					end else begin
						sprite_idx++;
					end
				end else begin
					list_bytes[list_fill] = bus;
					list_fill++;
					byte_idx++;
					if (byte_idx >= 4) begin
						byte_idx = 0;
						sprite_idx++;
					end
				end
			end else begin
				// list full: diagonal overflow search
				if (sprite_on_line(line, bus)) begin
					hit = 1'b1;
					byte_idx = (byte_idx + 1) & 3;
				end
				sprite_idx++;
			end
			if (sprite_idx >= SPRITE_COUNT)
				eval_done = 1'b1;
			return hit;
		endfunction

		function bus_result_t dot_tick(int unsigned line, int unsigned dot_no);
			bus_result_t res;
			int unsigned phase;
			int unsigned idx;
			res = '0;
			if (rendering_dot(line, dot_no)) begin
				if (dot_no == DOT_FIRST)
					restart_eval();
				if (dot_no <= DOT_CLEAR_END) begin
					foreach (list_bytes[i]) list_bytes[i] = BUS_IDLE;
					bus = BUS_IDLE;
				end else if (dot_no <= DOT_EVAL_END) begin
					if (dot_no == DOT_EVAL_GO)
						restart_eval();
					if (eval_done || sprite_idx >= SPRITE_COUNT) begin
						bus = BUS_IDLE;
						eval_done = 1'b1;
					end else begin
						res.hit = evaluate_dot(line, dot_no);
					end
				end else if (dot_no <= DOT_FETCH_END) begin
					phase = dot_no - DOT_FETCH_GO;
					idx = ((phase >> 3) << 2) | ((phase >> 1) & 3);
					bus = (idx < LIST_BYTES) ? list_bytes[idx] : BUS_IDLE;
					res.clr = 1'b1;
				end else begin
					bus = table_bytes[0];
					res.clr = 1'b1;
				end
			end
			res.data = bus;
			return res;
		endfunction

		// Accepted input transaction: update state, queue the result it owes
		function void note_item(item_t it);
			bus_result_t res;
			res = '0;
			case (it.kind)
				KIND_TICK:  res = dot_tick(it.scanline, it.dot);
				KIND_WRITE: table_bytes[it.table_address] = it.write_value;
				KIND_READ:  res.data = rendering_dot(it.scanline, it.dot) ? bus
					: table_bytes[it.table_address];
				default: ;
			endcase
			due_results.push_back(res);
		endfunction

		function void complain(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		// Accepted result transaction against the oldest expectation
		function void check_result(logic [7:0] got_data, logic got_hit, logic got_clr);
			bus_result_t want;
			if (due_results.size() == 0) begin
				complain("result transaction with no input waiting for it");
				return;
			end
			want = due_results.pop_front();
			if (got_data !== want.data || got_hit !== want.hit || got_clr !== want.clr)
				complain($sformatf({"result %0d: data %02h/%02h overflow_hit %0b/%0b ",
					"clear_address %0b/%0b (expected/actual)"}, checked, want.data, got_data,
					want.hit, got_hit, want.clr, got_clr));
			checked++;
		endfunction
	endclass

endpackage

[tb/sprite_list_evaluator_tb.sv]
`timescale 1ns / 1ps
// Top of the sprite list evaluator testbench: clock, reset, stimulus and handshake drivers.
// Depends on slev_pkg, slev_tb_pkg and the sprite_list_evaluator RTL.
module sprite_list_evaluator_tb;
	import slev_pkg::*;
	import slev_tb_pkg::*;

	localparam int RANDOM_ITEMS = 1000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 4;

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_ready;
	logic [1:0] kind;
	logic [8:0] scanline;
	logic [8:0] dot;
	logic [7:0] table_address;
	logic [7:0] write_value;
	logic       result_valid;
	logic       result_ready;
	logic [7:0] data;
	logic       overflow_hit;
	logic       clear_address;
	logic       cfg_we;
	logic       cfg_index;
	logic       cfg_data;

	sprite_eval_scoreboard eval_board = new();

	int items_sent     = 0;
	int hold_requests  = 0;
	bit sender_quiet   = 1'b0;
	bit receiver_quiet = 1'b0;

	sprite_list_evaluator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.kind          (kind),
		.scanline      (scanline),
		.dot           (dot),
		.table_address (table_address),
		.write_value   (write_value),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.data          (data),
		.overflow_hit  (overflow_hit),
		.clear_address (clear_address),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Mostly short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	// Result side: random stalls, plus long hold-offs on request
	initial begin
		int stall;
		int holds_served;
		stall = 0;
		holds_served = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				holds_served++;
				stall = HOLD_CYCLES;
			end else if (stall == 0 && !receiver_quiet && $urandom_range(0, 99) < 30) begin
				stall = idle_len();
			end
			if (stall > 0) begin
				result_ready <= 1'b0;
				stall--;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Result transactions
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			eval_board.check_result(data, overflow_hit, clear_address);
	end

	// Offer one input transaction; called and returns at a falling edge
	task automatic offer_item(input logic [1:0] k, input logic [8:0] ln, input logic [8:0] dt,
			input logic [7:0] ad, input logic [7:0] wv);
		item_t it;
		int gap;
		gap = sender_quiet ? 0 : idle_len();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		kind <= k;
		scanline <= ln;
		dot <= dt;
		table_address <= ad;
		write_value <= wv;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		it = '{kind: k, scanline: ln, dot: dt, table_address: ad, write_value: wv};
		eval_board.note_item(it);
		items_sent++;
		@(negedge clk);
	endtask

	// Stop sending and wait for every owed result, then let the pipeline empty
	task automatic settle();
		item_valid <= 1'b0;
		while (eval_board.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input reg_e idx, input logic val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		eval_board.set_config(idx, val);
		@(negedge clk);
	endtask

	// Any kind, any field value
	task automatic noise_item();
		logic [1:0] k;
		case ($urandom_range(0, 3))
			0: k = KIND_READ;
			1: k = KIND_WRITE;
			2: k = KIND_UNUSED;
			default: k = KIND_TICK;
		endcase
		offer_item(k, 9'($urandom), 9'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Place sprite tops just above the line so many land in range
	task automatic load_sprites(input int line, input bit tall_cfg);
		int n;
		int s;
		bit in_order;
		n = $urandom_range(6, 20);
		in_order = $urandom_range(0, 1);
		for (int i = 0; i < n; i++) begin
			s = in_order ? i : $urandom_range(0, SPRITE_COUNT - 1);
			offer_item(KIND_WRITE, 9'($urandom), 9'($urandom), 8'(s << 2),
				8'(line) - 8'($urandom_range(0, tall_cfg ? 20 : 12)));
		end
		// other bytes: tile, attribute, x, or stray tops
		repeat ($urandom_range(0, 8))
			offer_item(KIND_WRITE, 9'($urandom), 9'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Whole line of dot ticks with a little noise mixed in
	task automatic sweep_line(input int line);
		for (int d = 0; d <= DOT_LAST; d++) begin
			if ($urandom_range(0, 99) < 6)
				noise_item();
			offer_item(KIND_TICK, 9'(line), 9'(d), 8'($urandom), 8'($urandom));
		end
	endtask

	task automatic run_directed();
		// rendering off after reset
		offer_item(KIND_READ, 9'd0, 9'd0, 8'd0, 8'd0);
		offer_item(KIND_UNUSED, 9'h1FF, 9'h1FF, 8'hFF, 8'hFF);
		offer_item(KIND_WRITE, 9'd0, 9'd0, 8'hFF, 8'hFF);
		offer_item(KIND_WRITE, 9'd0, 9'd0, 8'h00, 8'h05);
		offer_item(KIND_READ, 9'h1FF, 9'h1FF, 8'hFF, 8'h00);
		offer_item(KIND_TICK, 9'd0, 9'd100, 8'd0, 8'd0);
		settle();
		write_reg(REG_RENDER, 1'b1);
		write_reg(REG_TALL, 1'b1);
		// idle ticks: line past the visible area, dot 0, dot past the line end
		offer_item(KIND_TICK, 9'd261, 9'd1, 8'd0, 8'd0);
		offer_item(KIND_TICK, 9'd239, 9'd0, 8'd0, 8'd0);
		offer_item(KIND_TICK, 9'd239, 9'd341, 8'd0, 8'd0);
		// clear, first evaluation pair, fetch and tail of line 5
		offer_item(KIND_TICK, 9'd5, 9'd1, 8'd0, 8'd0);
		offer_item(KIND_READ, 9'd5, 9'd64, 8'hFF, 8'd0);
		offer_item(KIND_TICK, 9'd5, 9'd64, 8'd0, 8'd0);
		offer_item(KIND_TICK, 9'd5, 9'd65, 8'd0, 8'd0);
		offer_item(KIND_TICK, 9'd5, 9'd66, 8'd0, 8'd0);
		offer_item(KIND_TICK, 9'd5, 9'd256, 8'd0, 8'd0);
		offer_item(KIND_TICK, 9'd5, 9'd257, 8'd0, 8'd0);
		offer_item(KIND_TICK, 9'd5, 9'd320, 8'd0, 8'd0);
		offer_item(KIND_TICK, 9'd5, 9'd321, 8'd0, 8'd0);
		offer_item(KIND_TICK, 9'd5, 9'd340, 8'd0, 8'd0);
		// write lands while rendering; read outside rendering sees the table
		offer_item(KIND_WRITE, 9'd5, 9'd200, 8'd1, 8'h80);
		offer_item(KIND_READ, 9'd240, 9'd5, 8'd1, 8'd0);
		settle();
	endtask

	// Main sequence
	initial begin
		int phase;
		int stop_at;
		int line;
		bit render;
		bit tall_cfg;
		arst_n = 1'b0;
		item_valid = 1'b0;
		kind = KIND_TICK;
		scanline = '0;
		dot = '0;
		table_address = '0;
		write_value = '0;
		cfg_we = 1'b0;
		cfg_index = REG_RENDER;
		cfg_data = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();

		stop_at = items_sent + RANDOM_ITEMS;
		phase = 0;
		while (items_sent < stop_at) begin
			settle();
			render = (phase < 2) ? 1'b1 : (phase == 2) ? 1'b0 : ($urandom_range(0, 4) != 0);
			tall_cfg = (phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : 1'($urandom_range(0, 1));
			write_reg(REG_RENDER, render);
			write_reg(REG_TALL, tall_cfg);
			sender_quiet = ($urandom_range(0, 3) == 0);
			receiver_quiet = ($urandom_range(0, 3) == 0);
			// long receiver hold-off while the line keeps streaming in
			if (phase == 1)
				hold_requests++;
			if (render) begin
				line = (phase == 0) ? 0 : (phase == 1) ? 239 : $urandom_range(0, 239);
				load_sprites(line, tall_cfg);
				sweep_line(line);
			end else begin
				repeat ($urandom_range(40, 80))
					noise_item();
			end
			phase++;
		end

		settle();
		if (eval_board.errors == 0 && eval_board.pending() == 0)
			$display("PASS sprite_list_evaluator");
		else
			$display("FAIL sprite_list_evaluator");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("FAIL sprite_list_evaluator");
		$finish;
	end

endmodule

[filelist.f]
src/slev_pkg.sv
src/slev_table.sv
src/slev_eval.sv
src/sprite_list_evaluator.sv
tb/slev_tb_pkg.sv
tb/sprite_list_evaluator_tb.sv
